FILE: sv/cca_pkg.sv
// shared types, register indexes and digit split helper for the calibrated clock
package cca_pkg;

  localparam logic [15:0] CalDropBit      = 16'h8000;
  localparam logic [15:0] CalIntervalMask = 16'h7FFF;
  localparam logic [6:0]  SecPerMin       = 7'd60;
  localparam logic [6:0]  MinPerHour      = 7'd60;
  localparam logic [5:0]  HoursPerDay     = 6'd24;

  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] RegCalibration = 2'd0;
  localparam logic [CfgIndexW-1:0] RegAlarmHour   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegAlarmMinute = 2'd2;

  typedef enum logic [1:0] {
    KindAdvance = 2'd0,
    KindSetTime = 2'd1,
    KindCheck   = 2'd2,
    KindMute    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] calibration;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  seconds_value;
    logic [5:0]  minutes_value;
    logic [4:0]  hours_value;
    logic        alarm_enable;
  } item_t;

  typedef struct packed {
    logic        alarm_active;
    logic        alarm_stop;
    logic        alarm_start;
    logic [3:0]  seconds_ones;
    logic [2:0]  seconds_tens;
    logic [3:0]  minutes_ones;
    logic [2:0]  minutes_tens;
    logic [3:0]  hours_ones;
    logic [1:0]  hours_tens;
  } result_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // decimal split of a value below 64
  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t d;
    logic [5:0] r;
    r = v;
    d.tens = 3'd0;
    priority if (v >= 6'd60) begin
      d.tens = 3'd6; r = v - 6'd60;
    end else if (v >= 6'd50) begin
      d.tens = 3'd5; r = v - 6'd50;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4; r = v - 6'd40;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3; r = v - 6'd30;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2; r = v - 6'd20;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1; r = v - 6'd10;
    end else begin
      d.tens = 3'd0; r = v;
    end
    d.ones = r[3:0];
    return d;
  endfunction

endpackage

FILE: sv/cca_cfg_regs.sv
// configuration register file: calibration and alarm time
module cca_cfg_regs import cca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibration  <= 16'd0;
      cfg_q.alarm_hour   <= 5'd8;
      cfg_q.alarm_minute <= 6'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCalibration: cfg_q.calibration  <= cfg_data_i;
        RegAlarmHour:   cfg_q.alarm_hour   <= cfg_data_i[4:0];
        RegAlarmMinute: cfg_q.alarm_minute <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/cca_tick.sv
// time of day, drift countdown and alarm latch with their next-state logic
module cca_tick import cca_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [4:0]         hour_q, hour_d;
  logic [5:0]         minute_q, minute_d;
  logic [5:0]         second_q, second_d;
  logic signed [15:0] drift_q, drift_d;
  logic               latch_q, latch_d;

  logic signed [16:0] drift_diff;
  logic [15:0]        drift_sat;
  logic               correct;
  logic [6:0]         amount;
  logic [6:0]         sec_sum;
  logic [1:0]         min_carry;
  logic [6:0]         min_sum;
  logic               hour_carry;
  logic [5:0]         hour_sum;
  logic [6:0]         sec_mod, min_mod;
  logic [5:0]         hour_mod;
  logic               start, stop;
  digits_t            hd, md, sd;

  // countdown falls by the amount and saturates at the most negative value
  always_comb begin
    drift_diff = {drift_q[15], drift_q} - {11'd0, item_i.seconds_value};
    if (drift_diff < -17'sd32768) begin
      drift_sat = 16'h8000;
    end else begin
      drift_sat = drift_diff[15:0];
    end
    correct = drift_sat[15] && (cfg_i.calibration != 16'd0);
    amount  = {1'b0, item_i.seconds_value};
    if (correct) begin
      if ((cfg_i.calibration & CalDropBit) != 16'd0) begin
        if (amount != 7'd0) amount = amount - 7'd1;
      end else begin
        amount = amount + 7'd1;
      end
    end
  end

  // carry chain; set time may leave counters above their range
  always_comb begin
    sec_sum = {1'b0, second_q} + amount;
    if (sec_sum >= 7'd120) begin
      sec_mod = sec_sum - 7'd120; min_carry = 2'd2;
    end else if (sec_sum >= SecPerMin) begin
      sec_mod = sec_sum - SecPerMin; min_carry = 2'd1;
    end else begin
      sec_mod = sec_sum; min_carry = 2'd0;
    end
    min_sum = {1'b0, minute_q} + {5'd0, min_carry};
    if (min_sum >= MinPerHour) begin
      min_mod = min_sum - MinPerHour; hour_carry = 1'b1;
    end else begin
      min_mod = min_sum; hour_carry = 1'b0;
    end
    hour_sum = {1'b0, hour_q} + {5'd0, hour_carry};
    if (hour_sum >= HoursPerDay) begin
      hour_mod = hour_sum - HoursPerDay;
    end else begin
      hour_mod = hour_sum;
    end
  end

  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    drift_d  = drift_q;
    latch_d  = latch_q;
    start    = 1'b0;
    stop     = 1'b0;
    unique case (item_i.kind)
      KindAdvance: begin
        second_d = sec_mod[5:0];
        minute_d = min_mod[5:0];
        hour_d   = hour_mod[4:0];
        drift_d  = correct ? signed'(cfg_i.calibration & CalIntervalMask)
                           : signed'(drift_sat);
      end
      KindSetTime: begin
        second_d = item_i.seconds_value;
        minute_d = item_i.minutes_value;
        hour_d   = item_i.hours_value;
      end
      KindCheck: begin
        if (item_i.alarm_enable && !latch_q && cfg_i.alarm_hour == hour_q
            && cfg_i.alarm_minute == minute_q) begin
          latch_d = 1'b1;
          start   = 1'b1;
        end
      end
      KindMute: begin
        latch_d = 1'b0;
        stop    = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    hd = split_digits({1'b0, hour_d});
    md = split_digits(minute_d);
    sd = split_digits(second_d);
    result_o.hours_tens   = hd.tens[1:0];
    result_o.hours_ones   = hd.ones;
    result_o.minutes_tens = md.tens;
    result_o.minutes_ones = md.ones;
    result_o.seconds_tens = sd.tens;
    result_o.seconds_ones = sd.ones;
    result_o.alarm_start  = start;
    result_o.alarm_stop   = stop;
    result_o.alarm_active = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      second_q <= 6'd0;
      drift_q  <= 16'sd0;
      latch_q  <= 1'b0;
    end else if (accept_i) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      drift_q  <= drift_d;
      latch_q  <= latch_d;
    end
  end

endmodule

FILE: sv/calibrated_clock_with_alarm_core.sv
// calibrated 24-hour clock with alarm: stream ports, config port, result register
// a result is registered, valid at the master the cycle after its input transfer
// throughput: one item per cycle unless the master stalls; one pass of tick logic
// the slave side stays ready while the result register is empty or being drained
// reset clears time, drift countdown and alarm latch; calibration 0, alarm 08:30
module calibrated_clock_with_alarm_core import cca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // seconds_value[5:0], minutes_value[11:6], hours_value[16:12], alarm_enable[17]
  input  logic [23:0]          s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hours_tens[1:0], hours_ones[5:2], minutes_tens[8:6], minutes_ones[12:9],
  // seconds_tens[15:13], seconds_ones[19:16], alarm_start[20], alarm_stop[21],
  // alarm_active[22]
  output logic [23:0]          m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  result_t result_q;
  logic    out_valid_q;
  logic    accept;

  assign item.kind          = kind_e'(s_axis_tuser);
  assign item.seconds_value = s_axis_tdata[5:0];
  assign item.minutes_value = s_axis_tdata[11:6];
  assign item.hours_value   = s_axis_tdata[16:12];
  assign item.alarm_enable  = s_axis_tdata[17];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cca_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cca_tick u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted item did not produce a result");

  a_start_stop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(result_q.alarm_start && result_q.alarm_stop))
    else $error("start and stop requested together");

  a_start_sets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.alarm_start) |-> result_q.alarm_active)
    else $error("start request without active alarm");

  a_stop_clears_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.alarm_stop) |-> !result_q.alarm_active)
    else $error("alarm still active after mute");

endmodule

FILE: test/tb_calibrated_clock_with_alarm_core.sv
// self-checking testbench for the calibrated clock with alarm core
module tb_calibrated_clock_with_alarm_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cca_pkg::*;

  localparam int unsigned DecBase = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = KindAdvance;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = RegCalibration;
  logic [15:0]          cfg_data_i = '0;

  calibrated_clock_with_alarm_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // clock model state and register copies
  logic [4:0]  hour_now = '0;
  logic [5:0]  minute_now = '0;
  logic [5:0]  second_now = '0;
  int          drift_left = 0;
  logic        alarm_on = 1'b0;
  logic [15:0] cal_reg = '0;
  logic [4:0]  alarm_hour_reg = 5'd8;
  logic [5:0]  alarm_minute_reg = 6'd30;

  result_t     pending_digits[$];
  int          errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic result_t tick_clock(kind_e kind, logic [5:0] sec_v, logic [5:0] min_v,
                                         logic [4:0] hour_v, logic en);
    int unsigned amount, s, m, h;
    int          next_left;
    result_t     r;
    r = '0;
    case (kind)
      KindAdvance: begin
        amount = sec_v;
        next_left = drift_left - int'(amount);
        if (next_left < -32768) next_left = -32768;
        drift_left = next_left;
        if (drift_left < 0 && cal_reg != 16'd0) begin
          drift_left = int'(cal_reg & CalIntervalMask);
          if ((cal_reg & CalDropBit) != 16'd0) begin
            if (amount > 0) amount--;
          end else begin
            amount++;
          end
        end
        s = second_now + amount;
        m = minute_now + s / SecPerMin;
        h = hour_now + m / MinPerHour;
        second_now = 6'(s % SecPerMin);
        minute_now = 6'(m % MinPerHour);
        hour_now = 5'(h % HoursPerDay);
      end
      KindSetTime: begin
        second_now = sec_v;
        minute_now = min_v;
        hour_now = hour_v;
      end
      KindCheck: begin
        if (en && alarm_hour_reg == hour_now && alarm_minute_reg == minute_now && !alarm_on) begin
          alarm_on = 1'b1;
          r.alarm_start = 1'b1;
        end
      end
      default: begin
        alarm_on = 1'b0;
        r.alarm_stop = 1'b1;
      end
    endcase
    r.hours_tens = 2'(hour_now / DecBase);
    r.hours_ones = 4'(hour_now % DecBase);
    r.minutes_tens = 3'(minute_now / DecBase);
    r.minutes_ones = 4'(minute_now % DecBase);
    r.seconds_tens = 3'(second_now / DecBase);
    r.seconds_ones = 4'(second_now % DecBase);
    r.alarm_active = alarm_on;
    return r;
  endfunction

  task automatic send_item(kind_e kind, logic [5:0] sec_v, logic [5:0] min_v,
                           logic [4:0] hour_v, logic en);
    s_axis_tdata <= {6'd0, en, hour_v, min_v, sec_v};
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_digits.push_back(tick_clock(kind, sec_v, min_v, hour_v, en));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_register(logic [CfgIndexW-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCalibration: cal_reg = data;
      RegAlarmHour:   alarm_hour_reg = data[4:0];
      RegAlarmMinute: alarm_minute_reg = data[5:0];
      default: ;
    endcase
  endtask

  task automatic write_config(logic [15:0] cal, logic [4:0] ah, logic [5:0] am);
    drain_results();
    put_register(RegCalibration, cal);
    put_register(RegAlarmHour, {11'd0, ah});
    put_register(RegAlarmMinute, {10'd0, am});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_item();
    kind_e       kind;
    logic [5:0]  sec_v, min_v;
    logic [4:0]  hour_v;
    logic        en;
    int unsigned pick;
    pick = $urandom_range(99);
    sec_v = 6'($urandom);
    min_v = 6'($urandom);
    hour_v = 5'($urandom);
    en = 1'($urandom);
    if (pick < 40) begin
      kind = KindAdvance;
    end else if (pick < 60) begin
      kind = KindSetTime;
      // half the time land on the alarm time so checks can fire
      if ($urandom_range(1)) begin
        hour_v = alarm_hour_reg;
        min_v = alarm_minute_reg;
      end else if ($urandom_range(1)) begin
        sec_v = 6'($urandom_range(59));
        min_v = 6'($urandom_range(59));
        hour_v = 5'($urandom_range(23));
      end
    end else if (pick < 85) begin
      kind = KindCheck;
    end else begin
      kind = KindMute;
    end
    send_item(kind, sec_v, min_v, hour_v, en);
  endtask

  // time fields: wraps, carries and out-of-range set values
  task automatic test_time_fields();
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindSetTime, 6'd59, 6'd59, 5'd23, 1'b0);
    send_item(KindAdvance, 6'd1, 6'd0, 5'd0, 1'b0);
    send_item(KindAdvance, 6'd0, 6'd63, 5'd31, 1'b1);
    send_item(KindAdvance, 6'd60, 6'd0, 5'd0, 1'b0);
    send_item(KindAdvance, 6'd63, 6'd0, 5'd0, 1'b0);
    send_item(KindSetTime, 6'd63, 6'd63, 5'd31, 1'b1);
    send_item(KindAdvance, 6'd63, 6'd0, 5'd0, 1'b0);
    send_item(KindSetTime, 6'd0, 6'd0, 5'd0, 1'b0);
  endtask

  // alarm latch, start and stop pulses with the reset alarm time
  task automatic test_alarm();
    send_item(KindSetTime, 6'd15, 6'd30, 5'd8, 1'b0);
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b0);
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindMute, 6'd0, 6'd0, 5'd0, 1'b0);
    send_item(KindMute, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindSetTime, 6'd59, 6'd29, 5'd8, 1'b0);
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindAdvance, 6'd1, 6'd0, 5'd0, 1'b0);
    send_item(KindCheck, 6'd0, 6'd0, 5'd0, 1'b1);
    send_item(KindMute, 6'd0, 6'd0, 5'd0, 1'b0);
  endtask

  // drift correction: add, drop, drop floored at zero, saturation, extremes
  task automatic test_calibration();
    write_config(16'h0003, 5'd0, 6'd0);
    send_item(KindAdvance, 6'd5, 6'd0, 5'd0, 1'b0);
    send_item(KindAdvance, 6'd2, 6'd0, 5'd0, 1'b0);
    send_item(KindAdvance, 6'd2, 6'd0, 5'd0, 1'b0);
    write_config(16'h0000, 5'd31, 6'd63);
    send_item(KindAdvance, 6'd5, 6'd0, 5'd0, 1'b0);
    write_config(16'h8000, 5'd31, 6'd63);
    send_item(KindAdvance, 6'd0, 6'd0, 5'd0, 1'b0);
    send_item(KindAdvance, 6'd7, 6'd0, 5'd0, 1'b0);
    write_config(16'h0000, 5'd0, 6'd0);
    // walk the countdown down to its floor
    repeat (525) send_item(KindAdvance, 6'd63, 6'd0, 5'd0, 1'b0);
    write_config(16'h7FFF, 5'd23, 6'd59);
    send_item(KindAdvance, 6'd1, 6'd0, 5'd0, 1'b0);
    write_config(16'hFFFF, 5'd23, 6'd59);
    send_item(KindAdvance, 6'd63, 6'd0, 5'd0, 1'b0);
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     logic [15:0] cal, logic [4:0] ah, logic [5:0] am,
                                     int n);
    write_config(cal, ah, am);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_random_item();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[22:0];
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none actual %h", $time,
                 m_axis_tdata);
        errors++;
      end else begin
        want = pending_digits.pop_front();
        compare_field("hours_tens", want.hours_tens, got.hours_tens);
        compare_field("hours_ones", want.hours_ones, got.hours_ones);
        compare_field("minutes_tens", want.minutes_tens, got.minutes_tens);
        compare_field("minutes_ones", want.minutes_ones, got.minutes_ones);
        compare_field("seconds_tens", want.seconds_tens, got.seconds_tens);
        compare_field("seconds_ones", want.seconds_ones, got.seconds_ones);
        compare_field("alarm_start", want.alarm_start, got.alarm_start);
        compare_field("alarm_stop", want.alarm_stop, got.alarm_stop);
        compare_field("alarm_active", want.alarm_active, got.alarm_active);
        compare_field("tdata pad", 0, m_axis_tdata[23]);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_time_fields();
    test_alarm();
    test_calibration();
    test_random_traffic(0, 0, 16'h0004, 5'($urandom_range(23)), 6'($urandom_range(59)), 190);
    test_random_traffic(58, 0, 16'h8007, 5'd0, 6'd0, 190);
    test_random_traffic(0, 58, {1'($urandom), 15'($urandom_range(20, 1))},
                        5'($urandom_range(23)), 6'($urandom_range(59)), 190);
    test_random_traffic(31, 31, 16'($urandom), 5'd31, 6'd63, 190);
    drain_results();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: calibrated_clock_with_alarm_core.f
sv/cca_pkg.sv
sv/cca_cfg_regs.sv
sv/cca_tick.sv
sv/calibrated_clock_with_alarm_core.sv
test/tb_calibrated_clock_with_alarm_core.sv
